### design/sliding_window_trimmed_mean_top_macros.svh
// Assertion macros shared by the sliding window trimmed mean design.
`ifndef SLIDING_WINDOW_TRIMMED_MEAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_TRIMMED_MEAN_TOP_MACROS_SVH

// Combinational or implication check, sampled on clk, off in reset.
`define SWTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition in one cycle implies a result in the next.
`define SWTM_ASSERT_NEXT(lbl, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error("assertion failed");

`endif

### design/swtm_pkg.sv
// Package: widths, codes and types of the sliding window trimmed mean block.
`timescale 1ns / 1ps
package swtm_pkg;
  localparam int MAX_WINDOW  = 1024;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = SAMPLE_BITS + IDX_W;
  localparam int LEN_W       = 11;
  localparam int TRIM_W      = 9;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT = 2'd1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_AWT   = 9'b000000010,
    ST_SRD   = 9'b000000100,
    ST_SWT   = 9'b000001000,
    ST_SINS  = 9'b000010000,
    ST_STAIL = 9'b000100000,
    ST_FIN   = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

### design/swtm_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
module swtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/swtm_div.sv
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module swtm_div
  import swtm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output div_sts_t         sts
);
  logic [SUM_W-1:0]     q_r, q_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt, dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [LEN_W:0]       trial;

  assign trial = {rem_r, q_r[SUM_W-1]};

  // one shift-subtract step
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = LEN_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[LEN_W-1:0];
        q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = q_r;
  assign sts      = '{busy: busy_r, done: done_r};
endmodule

### design/sliding_window_trimmed_mean_top.sv
// Top level of the sliding window trimmed mean block.
`timescale 1ns / 1ps
// Once the window is full, each sample begins with a read of the oldest
// one from the arrival ring. The sorted window sits in a two-bank RAM and is
// copied bank to bank one element at a time (a read wait between; the old
// sample dropped, the new one placed), the middle sum is built during that
// copy, and a one-bit-per-cycle divider of 26 steps gives the mean when one
// is due. Ready is low while a sample is in work. The result waits in an
// output register and holds the block only if a second result is finished
// before the first is taken. A write to the window length or trim count
// register empties the window; no clearing pass.
`include "sliding_window_trimmed_mean_top_macros.svh"
module sliding_window_trimmed_mean_top
  import swtm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_trimmed_mean,
  output logic                   out_mean_valid,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);
  state_t st_r, st_nxt;
  logic [LEN_W-1:0]       win_r, len_eff, span;
  logic [TRIM_W-1:0]      trim_r;
  logic [CNT_W-1:0]       fill_r, fill_nxt, rd_r, rd_nxt, wr_r, wr_nxt;
  logic [IDX_W-1:0]       oldest_r, oldest_nxt;
  logic                   bank_r, bank_nxt;
  logic                   rm_r, rm_nxt, removed_r, removed_nxt;
  logic                   ins_r, ins_nxt, sumen_r, sumen_nxt;
  logic [SAMPLE_BITS-1:0] smp_r, smp_nxt, old_r, old_nxt, hold_r, hold_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic                   ovalid_r, ovalid_nxt, omv_r, omv_nxt;
  logic [SAMPLE_BITS-1:0] omean_r, omean_nxt;
  logic                   full, accept, cfg_clr, trim_ok;
  logic                   emit, adv, div_start;
  logic [SAMPLE_BITS-1:0] emit_val, arr_rdata, srt_rdata, arr_wdata;
  logic                   arr_we;
  logic [IDX_W-1:0]       arr_waddr;
  logic [LEN_W-1:0]       trim2;
  logic [SUM_W-1:0]       quo;
  div_sts_t               dsts;

  // effective window length and trim checks
  always_comb begin
    if (win_r == '0) len_eff = LEN_W'(1);
    else if (win_r > LEN_W'(MAX_WINDOW)) len_eff = LEN_W'(MAX_WINDOW);
    else len_eff = win_r;
  end
  assign trim2   = {1'b0, trim_r, 1'b0};
  assign trim_ok = trim2 < len_eff;
  assign span    = len_eff - trim2;
  assign full    = fill_r >= CNT_W'(len_eff);
  assign in_ready = (st_r == ST_IDLE);
  assign accept  = in_valid && in_ready;
  assign cfg_clr = cfg_we && (cfg_index == REG_WINDOW_LEN || cfg_index == REG_TRIM_COUNT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= LEN_W'(MAX_WINDOW);
      trim_r <= TRIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LEN: win_r  <= cfg_wdata[LEN_W-1:0];
        REG_TRIM_COUNT: trim_r <= cfg_wdata[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    st_nxt      = st_r;
    fill_nxt    = fill_r;
    oldest_nxt  = oldest_r;
    bank_nxt    = bank_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    rm_nxt      = rm_r;
    removed_nxt = removed_r;
    ins_nxt     = ins_r;
    sumen_nxt   = sumen_r;
    smp_nxt     = smp_r;
    old_nxt     = old_r;
    hold_nxt    = hold_r;
    sum_nxt     = sum_r;
    ovalid_nxt  = ovalid_r;
    omv_nxt     = omv_r;
    omean_nxt   = omean_r;
    emit        = 1'b0;
    emit_val    = smp_r;
    adv         = 1'b0;
    div_start   = 1'b0;
    arr_we      = 1'b0;
    arr_waddr   = oldest_r;
    arr_wdata   = smp_r;

    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          smp_nxt     = in_sample;
          rm_nxt      = full;
          removed_nxt = 1'b0;
          ins_nxt     = 1'b0;
          rd_nxt      = '0;
          wr_nxt      = '0;
          sum_nxt     = '0;
          sumen_nxt   = trim_ok &&
                        ((full ? fill_r : fill_r + 1'b1) == CNT_W'(len_eff));
          if (full) begin
            st_nxt = ST_AWT;
          end else begin
            arr_we    = 1'b1;
            arr_waddr = fill_r[IDX_W-1:0];
            arr_wdata = in_sample;
            st_nxt    = (fill_r == '0) ? ST_STAIL : ST_SRD;
          end
        end
      end
      ST_AWT: begin
        old_nxt    = arr_rdata;
        arr_we     = 1'b1;
        oldest_nxt = (CNT_W'(oldest_r) + 1'b1 == CNT_W'(len_eff)) ? '0 : oldest_r + 1'b1;
        st_nxt     = ST_SRD;
      end
      ST_SRD: st_nxt = ST_SWT;
      ST_SWT: begin
        if (rm_r && !removed_r && srt_rdata == old_r) begin
          removed_nxt = 1'b1;
          adv         = 1'b1;
        end else if (!ins_r && srt_rdata > smp_r) begin
          emit     = 1'b1;
          hold_nxt = srt_rdata;
          ins_nxt  = 1'b1;
          st_nxt   = ST_SINS;
        end else begin
          emit     = 1'b1;
          emit_val = srt_rdata;
          adv      = 1'b1;
        end
      end
      ST_SINS: begin
        emit     = 1'b1;
        emit_val = hold_r;
        adv      = 1'b1;
      end
      ST_STAIL: begin
        emit   = 1'b1;
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        bank_nxt = !bank_r;
        fill_nxt = rm_r ? fill_r : fill_r + 1'b1;
        if (sumen_r) begin
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_DIV: if (dsts.done) st_nxt = ST_DONE;
      ST_DONE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          omv_nxt    = sumen_r;
          omean_nxt  = sumen_r ? quo[SAMPLE_BITS-1:0] : '0;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    // step to the next stored element
    if (adv) begin
      rd_nxt = rd_r + 1'b1;
      if (rd_r + 1'b1 < fill_r) st_nxt = ST_SRD;
      else st_nxt = ins_nxt ? ST_FIN : ST_STAIL;
    end

    // write one element of the new sorted bank, add it if in the middle
    if (emit) begin
      wr_nxt = wr_r + 1'b1;
      if (sumen_r && wr_r >= CNT_W'(trim_r) &&
          wr_r < CNT_W'(len_eff) - CNT_W'(trim_r)) begin
        sum_nxt = sum_r + SUM_W'(emit_val);
      end
    end

    if (cfg_clr) begin
      fill_nxt   = '0;
      oldest_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      fill_r   <= '0;
      oldest_r <= '0;
      bank_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      bank_r   <= bank_nxt;
      ovalid_r <= ovalid_nxt;
    end
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    rm_r      <= rm_nxt;
    removed_r <= removed_nxt;
    ins_r     <= ins_nxt;
    sumen_r   <= sumen_nxt;
    smp_r     <= smp_nxt;
    old_r     <= old_nxt;
    hold_r    <= hold_nxt;
    sum_r     <= sum_nxt;
    omv_r     <= omv_nxt;
    omean_r   <= omean_nxt;
  end

  // arrival order ring
  swtm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_arrival (
    .clk   (clk),
    .we    (arr_we),
    .waddr (arr_waddr),
    .wdata (arr_wdata),
    .raddr (oldest_r),
    .rdata (arr_rdata)
  );

  // sorted window, two banks: read the current one, build the other
  swtm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2 * MAX_WINDOW)) u_sorted (
    .clk   (clk),
    .we    (emit),
    .waddr ({!bank_r, wr_r[IDX_W-1:0]}),
    .wdata (emit_val),
    .raddr ({bank_r, rd_r[IDX_W-1:0]}),
    .rdata (srt_rdata)
  );

  swtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (span),
    .quotient (quo),
    .sts      (dsts)
  );

  assign out_valid        = ovalid_r;
  assign out_trimmed_mean = omean_r;
  assign out_mean_valid   = omv_r;

  `SWTM_ASSERT(a_fill_bound, st_r != ST_IDLE || fill_r <= CNT_W'(len_eff))
  `SWTM_ASSERT(a_oldest_bound, CNT_W'(oldest_r) < CNT_W'(len_eff) || oldest_r == '0)
  `SWTM_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
  `SWTM_ASSERT(a_invalid_zero, !(ovalid_r && !omv_r) || omean_r == '0)
  `SWTM_ASSERT(a_div_only_in_div, !dsts.busy || st_r == ST_DIV)
endmodule
